// ===== rtl/wopa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wopa_pkg: shared types and constants of the outer-product accumulator
// Request and result structs, command codes and the triangle index tables.
// ----------------------------------------------------------------------------
package wopa_pkg;

	localparam int ENERGY_BITS  = 16;
	localparam int WEIGHT_BITS  = 16;
	localparam int CUT_BITS     = 16;
	localparam int SET_ID_BITS  = 4;
	localparam int FLAG_BITS    = 9;
	localparam int NUM_SETS_DEF = 9;
	localparam int NVEC         = 6;
	localparam int NTRI         = 21;
	localparam int KW           = 5;
	localparam int IDXW         = 3;
	localparam int SUM_BITS     = 64;
	localparam int PROD_BITS    = 2 * ENERGY_BITS;
	localparam int TERM_BITS    = PROD_BITS + WEIGHT_BITS + 1;
	localparam logic signed [ENERGY_BITS-1:0] ONE_VALUE = ENERGY_BITS'(16);
	localparam logic [FLAG_BITS-1:0] FLAGS_RESET = FLAG_BITS'(384);

	typedef enum logic [1:0] {
		CMD_ACC   = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_TOWER_CUT  = 1'b0,
		REG_TOWER_SETS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t                          command;
		logic [SET_ID_BITS-1:0]        set_id;
		logic signed [ENERGY_BITS-1:0] tc;
		logic signed [ENERGY_BITS-1:0] t1;
		logic signed [ENERGY_BITS-1:0] t2;
		logic signed [ENERGY_BITS-1:0] t3;
		logic signed [ENERGY_BITS-1:0] t4;
		logic [WEIGHT_BITS-1:0]        weight;
		logic signed [CUT_BITS-1:0]    cut_low_value;
		logic signed [CUT_BITS-1:0]    cut_high_value;
	} req_t;

	typedef struct packed {
		logic [IDXW-1:0]            row;
		logic [IDXW-1:0]            col;
		logic signed [SUM_BITS-1:0] sum_value;
		logic                       last;
	} res_t;

	function automatic logic [IDXW-1:0] tri_row(input logic [KW-1:0] k);
		logic [IDXW-1:0] r;
		if (k < KW'(6)) r = IDXW'(0);
		else if (k < KW'(11)) r = IDXW'(1);
		else if (k < KW'(15)) r = IDXW'(2);
		else if (k < KW'(18)) r = IDXW'(3);
		else if (k < KW'(20)) r = IDXW'(4);
		else r = IDXW'(5);
		return r;
	endfunction

	function automatic logic [IDXW-1:0] tri_col(input logic [KW-1:0] k);
		logic [KW-1:0] c;
		if (k < KW'(6)) c = k;
		else if (k < KW'(11)) c = k - KW'(5);
		else if (k < KW'(15)) c = k - KW'(9);
		else if (k < KW'(18)) c = k - KW'(12);
		else if (k < KW'(20)) c = k - KW'(14);
		else c = KW'(5);
		return c[IDXW-1:0];
	endfunction

endpackage

// ===== rtl/wopa_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wopa_mac: shared weighted multiply-accumulate unit
// Two multiply stages followed by a saturating add into the sum memory.
// ----------------------------------------------------------------------------
module wopa_mac import wopa_pkg::*; #(
	parameter int AW = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic signed [ENERGY_BITS-1:0] vi,
	input  logic signed [ENERGY_BITS-1:0] vj,
	input  logic [WEIGHT_BITS-1:0]        weight,
	input  logic [AW-1:0]                 addr,
	input  logic signed [SUM_BITS-1:0]    old_s1,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic signed [SUM_BITS-1:0]    wr_data
);

	logic                          go_s1, go_s2;
	logic [AW-1:0]                 addr_s1, addr_s2;
	logic signed [PROD_BITS-1:0]   prod_s1;
	logic signed [TERM_BITS-1:0]   term_s2;
	logic signed [SUM_BITS-1:0]    old_s2;
	logic signed [SUM_BITS:0]      sum_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
		end else begin
			go_s1 <= go;
			go_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= vi * vj;
		addr_s1 <= addr;
		term_s2 <= TERM_BITS'(prod_s1) * TERM_BITS'($signed({1'b0, weight}));
		old_s2  <= old_s1;
		addr_s2 <= addr_s1;
	end

	// The weighted product always fits in 64 bits; only the addition saturates.
	assign sum_wide = {old_s2[SUM_BITS-1], old_s2} + (SUM_BITS+1)'(term_s2);

	always_comb begin
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			wr_data = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
				: {1'b0, {(SUM_BITS-1){1'b1}}};
		end else begin
			wr_data = sum_wide[SUM_BITS-1:0];
		end
	end

	assign wr_en   = go_s2;
	assign wr_addr = addr_s2;

endmodule

// ===== rtl/weighted_outer_product_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_outer_product_accumulator: per-set weighted normal-equation sums
// Accumulates weight times the upper-triangle products of (tc, t1..t4, 1).
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Accumulate runs
// the 21 triangle entries through one shared multiply-accumulate unit, one
// entry per cycle. Read sums issues one memory read per cycle and shows
// the 21 sums on result with result_valid high for one cycle each,
// row-major, last set on the final one. Load cuts and clear give no
// result; clear marks a set (or every set) empty through per-set valid
// flags. Requests rejected by the cuts or naming a missing set give no
// result either. The receiver cannot stall: each result is present for
// exactly one cycle. The cfg port is always ready and writes tower_cut
// (index 0) or tower_sets (index 1). Reset empties all sets, zeroes all
// cuts and restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module weighted_outer_product_accumulator import wopa_pkg::*; #(
	parameter int NUM_SETS = NUM_SETS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  result_valid,
	output res_t                  result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CUT_BITS-1:0]   cfg_data
);

	localparam int SETW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int AW   = SETW + KW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_READ,
		ST_DRAIN
	} state_t;

	state_t                        state_q;
	logic [KW-1:0]                 k_q;
	logic [1:0]                    drain_q;
	logic [SETW-1:0]               set_q;
	logic                          vld_q;
	logic [NUM_SETS-1:0]           set_vld_q;
	logic signed [CUT_BITS-1:0]    cut_low_q [NUM_SETS];
	logic signed [CUT_BITS-1:0]    cut_high_q [NUM_SETS];
	logic signed [CUT_BITS-1:0]    tower_cut_q;
	logic [FLAG_BITS-1:0]          tower_sets_q;
	logic signed [ENERGY_BITS-1:0] vec_q [NVEC];
	logic [WEIGHT_BITS-1:0]        weight_q;
	logic signed [SUM_BITS-1:0]    mem [(1 << SETW) * 32];
	logic signed [SUM_BITS-1:0]    rdata_s1;
	logic                          rd_s1;
	logic [KW-1:0]                 k_s1;

	logic                          accept;
	logic                          in_range;
	logic [SETW-1:0]               sid;
	logic                          win_ok;
	logic                          tower_on;
	logic                          tower_ok;
	logic                          issue;
	logic [AW-1:0]                 rd_addr;
	logic signed [SUM_BITS-1:0]    old_s1;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic signed [SUM_BITS-1:0]    wr_data;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign in_range  = (32'(req.set_id) < NUM_SETS);
	assign sid       = SETW'(req.set_id);
	assign win_ok    = in_range && (req.tc >= cut_low_q[sid]) && (req.tc <= cut_high_q[sid]);
	assign tower_on  = (32'(req.set_id) < FLAG_BITS) && tower_sets_q[req.set_id];
	assign tower_ok  = !tower_on || ((req.t1 >= tower_cut_q) && (req.t2 >= tower_cut_q)
		&& (req.t3 >= tower_cut_q) && (req.t4 >= tower_cut_q));
	assign issue     = (state_q == ST_ACC) || (state_q == ST_READ);
	assign rd_addr   = {set_q, k_q};
	assign old_s1    = vld_q ? rdata_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tower_cut_q  <= '0;
			tower_sets_q <= FLAGS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TOWER_CUT:  tower_cut_q  <= cfg_data;
				REG_TOWER_SETS: tower_sets_q <= cfg_data[FLAG_BITS-1:0];
				default:        tower_cut_q  <= tower_cut_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			drain_q   <= '0;
			set_q     <= '0;
			vld_q     <= 1'b0;
			set_vld_q <= '0;
			rd_s1     <= 1'b0;
			k_s1      <= '0;
			for (int s = 0; s < NUM_SETS; s++) begin
				cut_low_q[s]  <= '0;
				cut_high_q[s] <= '0;
			end
		end else begin
			rd_s1 <= (state_q == ST_READ);
			k_s1  <= k_q;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q   <= '0;
						set_q <= sid;
						vld_q <= in_range && set_vld_q[sid];
						unique case (req.command)
							CMD_ACC: begin
								if (win_ok && tower_ok) begin
									set_vld_q[sid] <= 1'b1;
									state_q        <= ST_ACC;
								end
							end
							CMD_LOAD: begin
								if (in_range) begin
									cut_low_q[sid]  <= req.cut_low_value;
									cut_high_q[sid] <= req.cut_high_value;
								end
							end
							CMD_CLEAR: begin
								if (in_range) set_vld_q[sid] <= 1'b0;
								else set_vld_q <= '0;
							end
							CMD_READ: begin
								if (in_range) state_q <= ST_READ;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ACC, ST_READ: begin
					k_q <= k_q + KW'(1);
					if (k_q == KW'(NTRI - 1)) begin
						drain_q <= 2'd2;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 2'd1;
					if (drain_q == 2'd1) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vec_q[0] <= req.tc;
			vec_q[1] <= req.t1;
			vec_q[2] <= req.t2;
			vec_q[3] <= req.t3;
			vec_q[4] <= req.t4;
			vec_q[5] <= ONE_VALUE;
			weight_q <= req.weight;
		end
		if (issue) rdata_s1 <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	wopa_mac #(
		.AW(AW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (state_q == ST_ACC),
		.vi      (vec_q[tri_row(k_q)]),
		.vj      (vec_q[tri_col(k_q)]),
		.weight  (weight_q),
		.addr    (rd_addr),
		.old_s1  (old_s1),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign result_valid     = rd_s1;
	assign result.row       = tri_row(k_s1);
	assign result.col       = tri_col(k_s1);
	assign result.sum_value = old_s1;
	assign result.last      = rd_s1 && (k_s1 == KW'(NTRI - 1));

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result after last sum of a readout");
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result while idle");
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_ACC || state_q == ST_DRAIN))
		else $error("sum write outside accumulate");
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && result_valid))
		else $error("accumulate and readout overlap");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the weighted outer-product accumulator
// Drives accumulate, load-cut, clear and read requests with random gaps,
// predicts every read-out sum and checks each result as it appears.
// ----------------------------------------------------------------------------
module tb_top;
	import wopa_pkg::*;

	localparam int NSETS = NUM_SETS_DEF;
	localparam logic signed [63:0] SUM_MAX = 64'sh7fffffffffffffff;
	localparam logic signed [63:0] SUM_MIN = 64'sh8000000000000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic result_valid;
	res_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CUT_BITS-1:0] cfg_data = '0;

	weighted_outer_product_accumulator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic signed [63:0] acc_sums [NSETS][NTRI];
	logic signed [15:0] win_low [NSETS];
	logic signed [15:0] win_high [NSETS];
	logic signed [15:0] min_tower;
	logic [FLAG_BITS-1:0] tower_flags;

	req_t pending_reqs [$];
	res_t expected_sums [$];
	int errors = 0;
	int gap = 0;
	bit gen_done = 0;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(SUM_MAX)) return SUM_MAX;
		if (s < 65'(SUM_MIN)) return SUM_MIN;
		return s[63:0];
	endfunction

	// Updates the sums and cut windows and queues expected read-out for one accepted request.
	task automatic predict_request(input req_t r);
		logic signed [31:0] v [NVEC];
		logic signed [63:0] prod;
		logic signed [80:0] term;
		int k;
		bit pass;
		if (r.command == CMD_CLEAR) begin
			for (int s = 0; s < NSETS; s++)
				if (r.set_id >= NSETS || s == r.set_id)
					for (int e = 0; e < NTRI; e++) acc_sums[s][e] = 0;
			return;
		end
		if (r.set_id >= NSETS) return;
		if (r.command == CMD_LOAD) begin
			win_low[r.set_id] = r.cut_low_value;
			win_high[r.set_id] = r.cut_high_value;
			return;
		end
		if (r.command == CMD_READ) begin
			k = 0;
			for (int i = 0; i < NVEC; i++)
				for (int j = i; j < NVEC; j++) begin
					expected_sums.push_back('{row: IDXW'(i), col: IDXW'(j),
						sum_value: acc_sums[r.set_id][k], last: (k == NTRI - 1)});
					k++;
				end
			return;
		end
		v[0] = r.tc; v[1] = r.t1; v[2] = r.t2; v[3] = r.t3; v[4] = r.t4; v[5] = 16;
		pass = (r.tc >= win_low[r.set_id]) && (r.tc <= win_high[r.set_id]);
		if (pass && tower_flags[r.set_id])
			for (int i = 1; i < 5; i++)
				if (v[i] < 32'(min_tower)) pass = 0;
		if (!pass) return;
		k = 0;
		for (int i = 0; i < NVEC; i++)
			for (int j = i; j < NVEC; j++) begin
				prod = 64'(v[i]) * 64'(v[j]);
				term = 81'(prod) * $signed({1'b0, 64'(r.weight)});
				if (term > 81'(SUM_MAX)) term = 81'(SUM_MAX);
				if (term < 81'(SUM_MIN)) term = 81'(SUM_MIN);
				acc_sums[r.set_id][k] = sat_add64(acc_sums[r.set_id][k], term[63:0]);
				k++;
			end
	endtask

	function automatic logic signed [15:0] rand_energy();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 400)) - 16'sd200;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t make_req(input cmd_t c, input int s);
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom, $urandom});
		r.command = c;
		r.set_id = SET_ID_BITS'(s);
		return r;
	endfunction

	// Driver: issues queued requests with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_request(req);
				void'(pending_reqs.pop_front());
				gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
				start <= 1'b0;
			end else if (gap > 0) begin
				gap <= gap - 1;
			end else if (pending_reqs.size() > 0) begin
				req <= pending_reqs[0];
				start <= 1'b1;
			end
		end
	end

	// Monitor: checks every result strobe against the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && result_valid) begin
			if (expected_sums.size() == 0) begin
				report("result with none expected");
			end else begin
				e = expected_sums.pop_front();
				if (result.row !== e.row) report($sformatf("row %0d exp %0d", result.row, e.row));
				if (result.col !== e.col) report($sformatf("col %0d exp %0d", result.col, e.col));
				if (result.sum_value !== e.sum_value)
					report($sformatf("sum(%0d,%0d) %0d exp %0d", e.row, e.col,
						result.sum_value, e.sum_value));
				if (result.last !== e.last) report("last flag wrong");
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || start || expected_sums.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_TOWER_CUT) min_tower = val;
		else tower_flags = val[FLAG_BITS-1:0];
	endtask

	task automatic queue_read_all();
		for (int s = 0; s < NSETS; s++) pending_reqs.push_back(make_req(CMD_READ, s));
	endtask

	initial begin
		req_t r;
		int s;
		for (int a = 0; a < NSETS; a++) begin
			win_low[a] = 0; win_high[a] = 0;
			for (int e = 0; e < NTRI; e++) acc_sums[a][e] = 0;
		end
		min_tower = 0;
		tower_flags = FLAGS_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero-window events, extremes, bad sets, clears.
		r = make_req(CMD_ACC, 0); r.tc = 0; r.t1 = 16'sh7fff; r.t2 = 16'sh8000;
		r.t3 = 5; r.t4 = -5; r.weight = 16'hffff; pending_reqs.push_back(r);
		pending_reqs.push_back(make_req(CMD_READ, 0));
		r = make_req(CMD_LOAD, 1); r.cut_low_value = 16'sh8000; r.cut_high_value = 16'sh7fff;
		pending_reqs.push_back(r);
		for (int n = 0; n < 6; n++) begin
			r = make_req(CMD_ACC, 1); r.tc = 16'sh8000; r.t1 = 16'sh8000; r.t2 = 16'sh7fff;
			r.t3 = 16'sh8000; r.t4 = 16'sh8000; r.weight = 16'hffff; pending_reqs.push_back(r);
		end
		pending_reqs.push_back(make_req(CMD_READ, 1));
		r = make_req(CMD_LOAD, 2); r.cut_low_value = 100; r.cut_high_value = -100;
		pending_reqs.push_back(r);
		r = make_req(CMD_ACC, 2); r.tc = 0; pending_reqs.push_back(r);
		pending_reqs.push_back(make_req(CMD_READ, 2));
		r = make_req(CMD_LOAD, 7); r.cut_low_value = 16'sh8000; r.cut_high_value = 16'sh7fff;
		pending_reqs.push_back(r);
		r = make_req(CMD_ACC, 7); r.t1 = -1; r.weight = 3; pending_reqs.push_back(r);
		r = make_req(CMD_ACC, 7); r.t1 = 0; r.t2 = 1; r.t3 = 2; r.t4 = 3; r.weight = 0;
		pending_reqs.push_back(r);
		pending_reqs.push_back(make_req(CMD_READ, 7));
		pending_reqs.push_back(make_req(CMD_ACC, 12));
		pending_reqs.push_back(make_req(CMD_LOAD, 9));
		pending_reqs.push_back(make_req(CMD_READ, 15));
		pending_reqs.push_back(make_req(CMD_CLEAR, 1));
		pending_reqs.push_back(make_req(CMD_READ, 1));
		pending_reqs.push_back(make_req(CMD_CLEAR, 13));
		pending_reqs.push_back(make_req(CMD_READ, 0));
		wait_drained();

		// Random phases under several register settings.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(REG_TOWER_CUT, 16'h8000); write_reg(REG_TOWER_SETS, 16'h01ff); end
				1: begin write_reg(REG_TOWER_CUT, 16'h7fff); write_reg(REG_TOWER_SETS, 16'h0000); end
				2: begin write_reg(REG_TOWER_CUT, 16'h7fff); write_reg(REG_TOWER_SETS, 16'h01ff); end
				3: begin write_reg(REG_TOWER_CUT, 16'($urandom_range(0, 200)) - 16'd100);
					write_reg(REG_TOWER_SETS, 16'($urandom)); end
				default: begin write_reg(REG_TOWER_CUT, 16'($urandom));
					write_reg(REG_TOWER_SETS, 16'($urandom)); end
			endcase
			for (int n = 0; n < 20; n++) begin
				s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, NSETS - 1);
				case ($urandom_range(0, 9))
					0: begin
						r = make_req(CMD_LOAD, s);
						if ($urandom_range(0, 3) != 0) begin
							r.cut_low_value = 16'($urandom_range(0, 300)) - 16'sd300;
							r.cut_high_value = 16'($urandom_range(0, 300));
						end
					end
					1: r = make_req(CMD_CLEAR, ($urandom_range(0, 4) == 0) ? 9 + $urandom_range(0, 6) : s);
					2, 3: r = make_req(CMD_READ, s);
					default: begin
						r = make_req(CMD_ACC, s);
						r.tc = ($urandom_range(0, 3) == 0) ? rand_energy()
							: 16'($urandom_range(0, 400)) - 16'sd200;
						r.t1 = rand_energy(); r.t2 = rand_energy();
						r.t3 = rand_energy(); r.t4 = rand_energy();
						r.weight = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
					end
				endcase
				pending_reqs.push_back(r);
			end
			queue_read_all();
			wait_drained();
		end
		gen_done = 1;
	end

	initial begin
		wait (gen_done);
		if (errors == 0 && expected_sums.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/wopa_pkg.sv
rtl/wopa_mac.sv
rtl/weighted_outer_product_accumulator.sv
sim/tb_top.sv
